// File: hw/rtl/tagm_pkg.sv
// Shared constants, types and elaboration-time index functions for the
// tree automorphism generator multiplier. No dependencies.
package tagm_pkg;

  localparam int TREE_DEPTH_DEF = 6;
  localparam int KEY_W          = 42;
  localparam int FUNC_W         = 3;

  // Generator codes; the unused codes act as the identity.
  typedef enum logic [FUNC_W-1:0] {
    FUNC_ID = 3'd0,
    FUNC_A  = 3'd1,
    FUNC_B  = 3'd2,
    FUNC_C  = 3'd3,
    FUNC_D  = 3'd4
  } func_t;

  // Vertices are held in heap order: level l, vertex v sits at 2^l - 1 + v.
  function automatic int heap_idx(input int lvl, input int v);
    return (1 << lvl) - 1 + v;
  endfunction

  // From level three on, vertices at 3, 5 and 7 mod 8 are not stored in a key.
  function automatic bit is_rebuilt(input int lvl, input int v);
    int r;
    r = v % 8;
    return (lvl >= 3) && ((r == 3) || (r == 5) || (r == 7));
  endfunction

  // Key bit that carries a stored vertex.
  function automatic int key_pos(input int lvl, input int v);
    int pos;
    pos = 0;
    for (int l = 0; l < lvl; l++) begin
      for (int w = 0; w < (1 << l); w++) begin
        if (!is_rebuilt(l, w)) pos++;
      end
    end
    for (int w = 0; w < v; w++) begin
      if (!is_rebuilt(lvl, w)) pos++;
    end
    return pos;
  endfunction

  // Number of key bits that a tree of the given depth uses.
  function automatic int key_bits(input int depth);
    return key_pos(depth, 0);
  endfunction

  // Heap index of the vertex held at a key bit.
  function automatic int pos_to_heap(input int pos);
    int cnt;
    int res;
    cnt = 0;
    res = 0;
    for (int l = 0; l < 6; l++) begin
      for (int w = 0; w < (1 << l); w++) begin
        if (!is_rebuilt(l, w)) begin
          if (cnt == pos) res = heap_idx(l, w);
          cnt++;
        end
      end
    end
    return res;
  endfunction

  // Heap index of a vertex, or the sentinel when the vertex lies outside the tree.
  function automatic int vsel(input int lvl, input int v, input int sentinel);
    int res;
    res = sentinel;
    if (lvl >= 0 && lvl <= 5) begin
      if (v >= 0 && v < (1 << lvl)) res = heap_idx(lvl, v);
    end
    return res;
  endfunction

endpackage

// File: hw/rtl/tagm_unpack.sv
// First pipeline stage: expands a packed key into a full portrait, rebuilding
// the unstored vertices, and forms the generator portrait. Uses tagm_pkg.
module tagm_unpack #(
  parameter int DEPTH = tagm_pkg::TREE_DEPTH_DEF,
  parameter int NV    = (1 << DEPTH) - 1
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       vld_i,
  input  logic [tagm_pkg::KEY_W-1:0] key_i,
  input  logic [tagm_pkg::FUNC_W-1:0] func_i,
  output logic                       vld_o,
  output logic [NV-1:0]              a_o,
  output logic [NV-1:0]              b_o
);
  import tagm_pkg::*;

  function automatic logic [NV-1:0] gen_mask(input int skip);
    logic [NV-1:0] m;
    m = '0;
    for (int i = 1; i < DEPTH; i++) begin
      if ((i % 3) != skip) m[heap_idx(i, (1 << i) - 2)] = 1'b1;
    end
    return m;
  endfunction

  localparam logic [NV-1:0] GEN_B = gen_mask(0);
  localparam logic [NV-1:0] GEN_C = gen_mask(2);
  localparam logic [NV-1:0] GEN_D = gen_mask(1);

  logic [NV-1:0] elem;
  logic [NV:0]   pad;
  logic [NV-1:0] gen_nxt;
  logic          vld_r;
  logic [NV-1:0] a_r;
  logic [NV-1:0] b_r;

  // The top bit of pad is a constant zero that stands for vertices off the tree.
  assign pad = {1'b0, elem};

  for (genvar gi = 0; gi < DEPTH; gi++) begin : g_lvl
    for (genvar gj = 0; gj < (1 << gi); gj++) begin : g_vtx
      localparam int IDX = heap_idx(gi, gj);
      if (!is_rebuilt(gi, gj)) begin : g_stored
        assign elem[IDX] = key_i[key_pos(gi, gj)];
      end else if ((gj % 8) == 3) begin : g_r3
        localparam int T0 = vsel(gi, gj - 1, NV);
        localparam int T1 = vsel(gi, gj - 2, NV);
        localparam int T2 = vsel(gi, gj - 3, NV);
        localparam int T3 = vsel(gi - 1, gj / 2, NV);
        localparam int T4 = vsel(gi - 1, gj / 2 - 1, NV);
        localparam int T5 = vsel(gi - 2, gj / 4 + 1, NV);
        assign elem[IDX] = pad[T0] ^ pad[T1] ^ pad[T2] ^ pad[T3] ^ pad[T4] ^ pad[T5];
      end else if ((gj % 8) == 5) begin : g_r5
        localparam int T0 = vsel(gi, gj - 1, NV);
        localparam int T1 = vsel(gi, gj - 4, NV);
        localparam int T2 = vsel(gi, gj - 5, NV);
        localparam int T3 = vsel(gi - 1, gj / 2 + 1, NV);
        localparam int T4 = vsel(gi - 1, gj / 2 - 1, NV);
        localparam int T5 = vsel(gi - 2, gj / 4, NV);
        localparam int T6 = vsel(gi - 2, gj / 4 - 1, NV);
        assign elem[IDX] = pad[T0] ^ pad[T1] ^ pad[T2] ^ pad[T3] ^ pad[T4]
                         ^ (pad[T5] & pad[T6]);
      end else begin : g_r7
        localparam int T0 = vsel(gi, gj - 1, NV);
        localparam int T1 = vsel(gi, gj - 2, NV);
        localparam int T2 = vsel(gi, gj - 3, NV);
        localparam int T3 = vsel(gi - 1, gj / 2, NV);
        localparam int T4 = vsel(gi - 1, gj / 2 - 1, NV);
        localparam int T5 = vsel(gi - 2, gj / 4 - 1, NV);
        assign elem[IDX] = pad[T0] ^ pad[T1] ^ pad[T2] ^ pad[T3] ^ pad[T4] ^ pad[T5];
      end
    end
  end

  always_comb begin
    gen_nxt = '0;
    case (func_i)
      FUNC_ID: gen_nxt = '0;
      FUNC_A:  gen_nxt[0] = 1'b1;
      FUNC_B:  gen_nxt = GEN_B;
      FUNC_C:  gen_nxt = GEN_C;
      FUNC_D:  gen_nxt = GEN_D;
      default: gen_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    a_r <= elem;
    b_r <= gen_nxt;
  end

  assign vld_o = vld_r;
  assign a_o   = a_r;
  assign b_o   = b_r;

endmodule

// File: hw/rtl/tagm_perm.sv
// One composition stage: the element's activity at level LEVEL swaps the
// halves of the generator's subtrees below that level. Uses tagm_pkg.
module tagm_perm #(
  parameter int DEPTH = tagm_pkg::TREE_DEPTH_DEF,
  parameter int NV    = (1 << DEPTH) - 1,
  parameter int LEVEL = 0
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          vld_i,
  input  logic [NV-1:0] a_i,
  input  logic [NV-1:0] b_i,
  output logic          vld_o,
  output logic [NV-1:0] a_o,
  output logic [NV-1:0] b_o
);
  import tagm_pkg::*;

  logic [NV-1:0] b_nxt;
  logic          vld_r;
  logic [NV-1:0] a_r;
  logic [NV-1:0] b_r;

  for (genvar gi = 0; gi < DEPTH; gi++) begin : g_lvl
    for (genvar gj = 0; gj < (1 << gi); gj++) begin : g_vtx
      localparam int IDX = heap_idx(gi, gj);
      if (gi <= LEVEL) begin : g_keep
        assign b_nxt[IDX] = b_i[IDX];
      end else begin : g_swap
        localparam int SH   = gi - LEVEL;
        localparam int AIDX = heap_idx(LEVEL, gj >> SH);
        localparam int SIDX = heap_idx(gi, gj ^ (1 << (SH - 1)));
        assign b_nxt[IDX] = a_i[AIDX] ? b_i[SIDX] : b_i[IDX];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    a_r <= a_i;
    b_r <= b_nxt;
  end

  assign vld_o = vld_r;
  assign a_o   = a_r;
  assign b_o   = b_r;

endmodule

// File: hw/rtl/tagm_pack.sv
// Last pipeline stage: adds the permuted generator to the element at every
// vertex and packs the stored vertices into a key. Uses tagm_pkg.
module tagm_pack #(
  parameter int DEPTH = tagm_pkg::TREE_DEPTH_DEF,
  parameter int NV    = (1 << DEPTH) - 1
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       vld_i,
  input  logic [NV-1:0]              a_i,
  input  logic [NV-1:0]              b_i,
  output logic                       vld_o,
  output logic [tagm_pkg::KEY_W-1:0] key_o
);
  import tagm_pkg::*;

  localparam int KB = key_bits(DEPTH);

  logic [NV-1:0]    res;
  logic [KEY_W-1:0] key_nxt;
  logic             vld_r;
  logic [KEY_W-1:0] key_r;

  assign res = a_i ^ b_i;

  for (genvar gp = 0; gp < KEY_W; gp++) begin : g_pos
    if (gp < KB) begin : g_used
      assign key_nxt[gp] = res[pos_to_heap(gp)];
    end else begin : g_unused
      assign key_nxt[gp] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

  assign vld_o = vld_r;
  assign key_o = key_r;

endmodule

// File: hw/rtl/tree_automorphism_generator_multiply.sv
// Throughput: one item per cycle; busy is always low. The pipeline holds one
// register stage for unpacking, one per tree level but the last for composition,
// and one for packing. Synchronous active-low reset clears the valid bits only.
// Depends on tagm_pkg, tagm_unpack, tagm_perm and tagm_pack.
module tree_automorphism_generator_multiply #(
  parameter int TREE_DEPTH = tagm_pkg::TREE_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [tagm_pkg::KEY_W-1:0]  in_element_key,
  input  logic [tagm_pkg::FUNC_W-1:0] in_func,
  output logic                        out_valid,
  output logic [tagm_pkg::KEY_W-1:0]  out_product_key
);
  import tagm_pkg::*;

  localparam int NV = (1 << TREE_DEPTH) - 1;

  logic [TREE_DEPTH-1:0]         vld_s;
  logic [TREE_DEPTH-1:0][NV-1:0] a_s;
  logic [TREE_DEPTH-1:0][NV-1:0] b_s;

  // Every cycle can take a transfer; nothing inside ever holds the input off.
  assign busy = 1'b0;

  tagm_unpack #(
    .DEPTH (TREE_DEPTH),
    .NV    (NV)
  ) u_unpack (
    .clk    (clk),
    .rst_n  (rst_n),
    .vld_i  (start),
    .key_i  (in_element_key),
    .func_i (in_func),
    .vld_o  (vld_s[0]),
    .a_o    (a_s[0]),
    .b_o    (b_s[0])
  );

  for (genvar gk = 0; gk < TREE_DEPTH - 1; gk++) begin : g_perm
    tagm_perm #(
      .DEPTH (TREE_DEPTH),
      .NV    (NV),
      .LEVEL (gk)
    ) u_perm (
      .clk   (clk),
      .rst_n (rst_n),
      .vld_i (vld_s[gk]),
      .a_i   (a_s[gk]),
      .b_i   (b_s[gk]),
      .vld_o (vld_s[gk+1]),
      .a_o   (a_s[gk+1]),
      .b_o   (b_s[gk+1])
    );
  end

  tagm_pack #(
    .DEPTH (TREE_DEPTH),
    .NV    (NV)
  ) u_pack (
    .clk   (clk),
    .rst_n (rst_n),
    .vld_i (vld_s[TREE_DEPTH-1]),
    .a_i   (a_s[TREE_DEPTH-1]),
    .b_i   (b_s[TREE_DEPTH-1]),
    .vld_o (out_valid),
    .key_o (out_product_key)
  );

endmodule

// File: test/tb_top.sv
// Self-checking testbench for the tree automorphism generator multiplier.
// Stimulus is directed then random, with a predictor in a scoreboard class.
// Depends on tagm_pkg and tree_automorphism_generator_multiply.
`timescale 1ns / 100ps

module tb_top;
  import tagm_pkg::*;

  localparam int DEPTH        = TREE_DEPTH_DEF;
  localparam int LATENCY      = DEPTH + 1;
  localparam int RANDOM_ITEMS = 1600;
  localparam int CYCLE_LIMIT  = 200000;

  typedef bit [5:0][31:0] portrait_t;

  class product_scoreboard;
    bit [KEY_W-1:0] expected_keys[$];
    int failures;
    int reported;

    function new();
      failures = 0;
      reported = 0;
    endfunction

    function bit skipped_vertex(int lvl, int v);
      int r;
      r = v % 8;
      return (lvl >= 3) && (r == 3 || r == 5 || r == 7);
    endfunction

    function bit tree_bit(portrait_t p, int lvl, int v);
      if (lvl < 0 || lvl > 5 || v < 0 || v >= (1 << lvl)) return 1'b0;
      return p[lvl][v];
    endfunction

    // Stored bits come straight from the key; the others follow from the
    // parity relations, one with an AND term, on bits of this level and the two above it.
    function portrait_t unpack_key(bit [KEY_W-1:0] key);
      portrait_t p;
      int pos;
      bit b;
      p = '0;
      pos = 0;
      for (int i = 0; i < DEPTH; i++) begin
        for (int j = 0; j < (1 << i); j++) begin
          if (skipped_vertex(i, j)) begin
            case (j % 8)
              3: b = tree_bit(p, i, j - 1) ^ tree_bit(p, i, j - 2) ^ tree_bit(p, i, j - 3)
                   ^ tree_bit(p, i - 1, j / 2) ^ tree_bit(p, i - 1, j / 2 - 1)
                   ^ tree_bit(p, i - 2, j / 4 + 1);
              5: b = tree_bit(p, i, j - 1) ^ tree_bit(p, i, j - 4) ^ tree_bit(p, i, j - 5)
                   ^ tree_bit(p, i - 1, j / 2 + 1) ^ tree_bit(p, i - 1, j / 2 - 1)
                   ^ (tree_bit(p, i - 2, j / 4) & tree_bit(p, i - 2, j / 4 - 1));
              default: b = tree_bit(p, i, j - 1) ^ tree_bit(p, i, j - 2)
                   ^ tree_bit(p, i, j - 3) ^ tree_bit(p, i - 1, j / 2)
                   ^ tree_bit(p, i - 1, j / 2 - 1) ^ tree_bit(p, i - 2, j / 4 - 1);
            endcase
          end else begin
            b = key[pos];
            pos++;
          end
          p[i][j] = b;
        end
      end
      return p;
    endfunction

    function portrait_t generator_portrait(bit [FUNC_W-1:0] code);
      portrait_t g;
      int skip;
      g = '0;
      if (code == FUNC_A) begin
        g[0][0] = 1'b1;
      end else if (code == FUNC_B || code == FUNC_C || code == FUNC_D) begin
        skip = (code == FUNC_B) ? 0 : (code == FUNC_C) ? 2 : 1;
        for (int i = 1; i < DEPTH; i++) begin
          if (i % 3 != skip) g[i][(1 << i) - 2] = 1'b1;
        end
      end
      return g;
    endfunction

    function bit [KEY_W-1:0] predict_product(bit [KEY_W-1:0] key, bit [FUNC_W-1:0] code);
      portrait_t a;
      portrait_t g;
      bit [31:0] swapped;
      bit [KEY_W-1:0] res;
      int u;
      int s;
      int pos;
      a = unpack_key(key);
      g = generator_portrait(code);
      // An active vertex of the element swaps the halves of the generator
      // below it before the levels are combined.
      for (int i = 0; i < DEPTH; i++) begin
        for (int j = i + 1; j < DEPTH; j++) begin
          swapped = '0;
          for (int v = 0; v < (1 << j); v++) begin
            u = v >> (j - i);
            s = a[i][u] ? (1 << (j - i - 1)) : 0;
            swapped[v] = g[j][v ^ s];
          end
          g[j] = swapped;
        end
        a[i] ^= g[i];
      end
      res = '0;
      pos = 0;
      for (int i = 0; i < DEPTH; i++) begin
        for (int j = 0; j < (1 << i); j++) begin
          if (!skipped_vertex(i, j)) begin
            res[pos] = a[i][j];
            pos++;
          end
        end
      end
      return res;
    endfunction

    function void note_input(bit [KEY_W-1:0] key, bit [FUNC_W-1:0] code);
      expected_keys.push_back(predict_product(key, code));
    endfunction

    function void check_result(bit [KEY_W-1:0] actual);
      bit [KEY_W-1:0] expected;
      if (expected_keys.size() == 0) begin
        failures++;
        if (reported < 10) $display("unexpected result: product_key %h", actual);
        reported++;
        return;
      end
      expected = expected_keys.pop_front();
      if (actual !== expected) begin
        failures++;
        if (reported < 10) begin
          $display("mismatch: product_key expected %h actual %h", expected, actual);
        end
        reported++;
      end
    endfunction

    function int pending();
      return expected_keys.size();
    endfunction
  endclass

  logic              clk;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [KEY_W-1:0]  in_element_key = '0;
  logic [FUNC_W-1:0] in_func = '0;
  logic              out_valid;
  logic [KEY_W-1:0]  out_product_key;

  product_scoreboard sb = new();
  int                sender_idle_pct = 0;

  tree_automorphism_generator_multiply #(
    .TREE_DEPTH(DEPTH)
  ) uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_element_key  (in_element_key),
    .in_func         (in_func),
    .out_valid       (out_valid),
    .out_product_key (out_product_key)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Values are read straight after the edge, so they are those the block saw.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) sb.check_result(out_product_key);
      if (start && !busy) sb.note_input(in_element_key, in_func);
    end
  end

  // Start is left high after a transfer so that back-to-back items need no
  // second assignment in the same step.
  task automatic send_item(input logic [KEY_W-1:0] key, input logic [FUNC_W-1:0] code);
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start          <= 1'b1;
    in_element_key <= key;
    in_func        <= code;
    do @(posedge clk); while (busy);
  endtask

  task automatic send_random_item();
    logic [KEY_W-1:0] key;
    logic [FUNC_W-1:0] code;
    key = KEY_W'({$urandom, $urandom});
    case ($urandom_range(7))
      0: key = {{(KEY_W-1){1'b0}}, 1'b1} << $urandom_range(KEY_W - 1);
      1: key = ~({{(KEY_W-1){1'b0}}, 1'b1} << $urandom_range(KEY_W - 1));
      default: ;
    endcase
    code = ($urandom_range(15) < 13) ? FUNC_W'($urandom_range(4))
                                     : FUNC_W'($urandom_range(7, 5));
    send_item(key, code);
  endtask

  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb_top: FAIL");
    $finish;
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: empty and full keys with every code, including the
    // unused ones, then single bits at both ends, alternating patterns and block patterns.
    for (int f = 0; f < 8; f++) send_item('0, FUNC_W'(f));
    for (int f = 0; f < 8; f++) send_item('1, FUNC_W'(f));
    send_item(42'h000_0000_0001, FUNC_B);
    send_item(42'h200_0000_0000, FUNC_D);
    send_item(42'h155_5555_5555, FUNC_C);
    send_item(42'h2aa_aaaa_aaaa, FUNC_A);
    send_item(42'h155_5555_5555, FUNC_D);
    send_item(42'h2aa_aaaa_aaaa, FUNC_B);
    send_item(42'h3ff_0000_ffff, FUNC_C);
    send_item(42'h000_ffff_0000, FUNC_ID);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n < RANDOM_ITEMS / 3) sender_idle_pct = 11;
      else if (n < 2 * RANDOM_ITEMS / 3) sender_idle_pct = 82;
      else sender_idle_pct = 0;
      send_random_item();
    end
    start <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (2 * LATENCY + 4) @(posedge clk);

    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
